/* src/assert_macros.svh */
// Assertion macros used by the verification checks of the fall detector.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while the reset is high.
`define AFD_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fall detector assertion failed");

// Concurrent assertion that is checked at every edge, reset included.
`define AFD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("fall detector assertion failed");

`endif

/* src/afd_pkg.sv */
// Shared types and constants of the accelerometer fall detector.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package afd_pkg;

   localparam int WINDOW = 5;
   localparam int IDX_W  = $clog2(WINDOW);
   localparam int LOG_W  = $clog2(WINDOW);

   localparam int AXIS_W = 16;
   localparam int MAG_W  = 24;
   localparam int SQ_W   = 32;
   localparam int RAD_W  = 2 * MAG_W;
   localparam int REM_W  = MAG_W + 2;
   localparam int SQRT_STEPS = MAG_W;
   localparam int STEP_W = $clog2(SQRT_STEPS);

   localparam int S_W    = MAG_W + LOG_W;
   localparam int Q_W    = 2 * MAG_W + LOG_W;
   localparam int D_W    = 2 * MAG_W + 2 * LOG_W;
   localparam int L2_W   = 16;
   localparam int DL_W   = D_W + L2_W;
   localparam int LO_W   = 32 + L2_W;
   localparam int MUL_W  = 32;
   localparam int PROD_W = 2 * MUL_W;
   localparam int TAN_W  = 24;
   localparam int TILT_W = TAN_W + AXIS_W;

   localparam int CV_W     = 8;
   localparam int SETTLE_W = 16;

   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_CV_LIMIT     = 2'd0;
   localparam logic [1:0] REG_SETTLE_TICKS = 2'd1;
   localparam logic [1:0] REG_TILT_TANGENT = 2'd2;

   localparam logic [CV_W-1:0]     CV_LIMIT_RST     = 8'd10;
   localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST = 16'd500;
   localparam logic [TAN_W-1:0]    TILT_TANGENT_RST = 24'd244586;

   localparam logic OPERATION_SAMPLE = 1'b0;
   localparam logic OPERATION_TICK   = 1'b1;

   typedef enum logic [4:0] {
      DP_NONE,
      DP_LOAD,
      DP_MUL_X,
      DP_MUL_Y,
      DP_MUL_Z,
      DP_SQ_ADD,
      DP_SQRT_INIT,
      DP_SQRT_STEP,
      DP_WRITE,
      DP_EV_CLEAR,
      DP_EV_READ,
      DP_EV_MUL,
      DP_EV_ACC,
      DP_S2,
      DP_DIFF,
      DP_PLO,
      DP_PHI,
      DP_SUM,
      DP_CMP,
      DP_TILT_MUL,
      DP_TILT_CMP
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic [IDX_W-1:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic var_low;
      logic fall;
   } dp_stat_type;

endpackage

/* src/accel_fall_detector.sv */
// Top level of the accelerometer fall detector: stream ports, register port,
// controller and datapath. Depends on afd_pkg, afd_ctrl and afd_dp.
`timescale 1ns / 1ps

// The block takes accelerometer samples and millisecond ticks on the request
// stream and reports fall decisions on the response stream. A tick is taken in
// the idle state. A sample that fills the window goes through the 24-step
// square root that turns x*x+y*y+z*z into a magnitude with 8 fraction bits.
// The sample that completes the window then runs the variation test, which
// walks the stored magnitudes one at a time through a single shared 32x32
// multiplier. The sample after the settling wait gets the tilt check. Samples
// that arrive while the block waits for the settling ticks are dropped. A
// response is held in an output register, so the block takes the next request
// while a decision waits to be read; a second decision waits until the first
// one is taken.

module accel_fall_detector (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // accel_x [15:0], accel_y [31:16], accel_z [47:32]
   input  logic [0:0]  req_tuser,  // operation [0]: 0 sample, 1 tick
   // Response stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // fall_detected [0], zero fill [7:1]
   output logic [0:0]  rsp_tuser,  // low_variation [0]
   // Register port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [afd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   logic [afd_pkg::CV_W-1:0]     cv_limit_ff;
   logic [afd_pkg::SETTLE_W-1:0] settle_ticks_ff;
   logic [afd_pkg::TAN_W-1:0]    tilt_tangent_ff;
   logic                         csr_write;
   logic [1:0]                   csr_index;
   afd_pkg::dp_cmd_type          cmd;
   afd_pkg::dp_stat_type         stat;
   logic                         rsp_fall;
   logic                         rsp_low;

   // Registers sit on word addresses; the two low address bits are ignored.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_limit_ff     <= afd_pkg::CV_LIMIT_RST;
         settle_ticks_ff <= afd_pkg::SETTLE_TICKS_RST;
         tilt_tangent_ff <= afd_pkg::TILT_TANGENT_RST;
      end else if (csr_write) begin
         case (csr_index)
            afd_pkg::REG_CV_LIMIT:     cv_limit_ff     <= csr_pwdata[afd_pkg::CV_W-1:0];
            afd_pkg::REG_SETTLE_TICKS: settle_ticks_ff <= csr_pwdata[afd_pkg::SETTLE_W-1:0];
            afd_pkg::REG_TILT_TANGENT: tilt_tangent_ff <= csr_pwdata[afd_pkg::TAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         afd_pkg::REG_CV_LIMIT:     csr_prdata = 32'(cv_limit_ff);
         afd_pkg::REG_SETTLE_TICKS: csr_prdata = 32'(settle_ticks_ff);
         afd_pkg::REG_TILT_TANGENT: csr_prdata = 32'(tilt_tangent_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // The controller owns the phase, the tick counter and the response register.
   afd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_op       (req_tuser[0]),
      .req_ready    (req_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_fall     (rsp_fall),
      .rsp_low      (rsp_low),
      .settle_ticks (settle_ticks_ff),
      .cmd          (cmd),
      .stat         (stat)
   );

   // The datapath holds the window and does all of the sample arithmetic.
   afd_dp u_dp (
      .clock        (clock),
      .cmd          (cmd),
      .req_x        (req_tdata[15:0]),
      .req_y        (req_tdata[31:16]),
      .req_z        (req_tdata[47:32]),
      .cv_limit     (cv_limit_ff),
      .tilt_tangent (tilt_tangent_ff),
      .stat         (stat)
   );

   assign rsp_tdata = {7'b000_0000, rsp_fall};
   assign rsp_tuser = rsp_low;

endmodule

/* src/afd_dp.sv */
// Datapath of the fall detector: sample squares, bit-serial square root,
// magnitude window, variation test and tilt test. Depends on afd_pkg.
`timescale 1ns / 1ps

module afd_dp (
   input  logic                                clock,
   input  afd_pkg::dp_cmd_type                 cmd,
   input  logic signed [afd_pkg::AXIS_W-1:0]   req_x,
   input  logic signed [afd_pkg::AXIS_W-1:0]   req_y,
   input  logic signed [afd_pkg::AXIS_W-1:0]   req_z,
   input  logic [afd_pkg::CV_W-1:0]            cv_limit,
   input  logic [afd_pkg::TAN_W-1:0]           tilt_tangent,
   output afd_pkg::dp_stat_type                stat
);

   logic signed [afd_pkg::AXIS_W-1:0] ax_ff, ay_ff, az_ff;
   logic [afd_pkg::AXIS_W-1:0]        abs_x, abs_y, abs_z;
   logic [afd_pkg::MUL_W-1:0]         mul_a, mul_b;
   logic [afd_pkg::PROD_W-1:0]        prod_ff;
   logic [afd_pkg::SQ_W-1:0]          sq_ff;
   logic [afd_pkg::RAD_W-1:0]         rad_ff;
   logic [afd_pkg::REM_W-1:0]         rem_ff;
   logic [afd_pkg::MAG_W-1:0]         root_ff;
   logic [afd_pkg::REM_W+1:0]         cur_rem;
   logic [afd_pkg::REM_W+1:0]         trial;
   logic [afd_pkg::MAG_W-1:0]         win_mem [afd_pkg::WINDOW];
   logic [afd_pkg::MAG_W-1:0]         rd_ff;
   logic [afd_pkg::S_W-1:0]           s_ff;
   logic [afd_pkg::Q_W-1:0]           q_ff;
   logic [afd_pkg::L2_W-1:0]          l2_ff;
   logic [afd_pkg::D_W-1:0]           d_ff;
   logic [afd_pkg::D_W-1:0]           s2_ff;
   logic [afd_pkg::LO_W-1:0]          lo_ff;
   logic [afd_pkg::DL_W-1:0]          dl_ff;
   logic                              low_ff;
   logic                              fall_ff;
   logic                              mul_en;

   // Magnitudes of the axes; the most negative value maps to 32768.
   assign abs_x = ax_ff[afd_pkg::AXIS_W-1] ? afd_pkg::AXIS_W'(-ax_ff) : afd_pkg::AXIS_W'(ax_ff);
   assign abs_y = ay_ff[afd_pkg::AXIS_W-1] ? afd_pkg::AXIS_W'(-ay_ff) : afd_pkg::AXIS_W'(ay_ff);
   assign abs_z = az_ff[afd_pkg::AXIS_W-1] ? afd_pkg::AXIS_W'(-az_ff) : afd_pkg::AXIS_W'(az_ff);

   // One shared multiplier; its operands depend on the command.
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      case (cmd.op)
         afd_pkg::DP_MUL_X: begin
            mul_a = afd_pkg::MUL_W'(abs_x);
            mul_b = afd_pkg::MUL_W'(abs_x);
         end
         afd_pkg::DP_MUL_Y: begin
            mul_a = afd_pkg::MUL_W'(abs_y);
            mul_b = afd_pkg::MUL_W'(abs_y);
         end
         afd_pkg::DP_MUL_Z: begin
            mul_a = afd_pkg::MUL_W'(abs_z);
            mul_b = afd_pkg::MUL_W'(abs_z);
         end
         afd_pkg::DP_EV_MUL: begin
            mul_a = afd_pkg::MUL_W'(rd_ff);
            mul_b = afd_pkg::MUL_W'(rd_ff);
         end
         afd_pkg::DP_S2: begin
            mul_a = afd_pkg::MUL_W'(s_ff);
            mul_b = afd_pkg::MUL_W'(s_ff);
         end
         afd_pkg::DP_PLO: begin
            mul_a = d_ff[31:0];
            mul_b = afd_pkg::MUL_W'(l2_ff);
         end
         afd_pkg::DP_PHI: begin
            mul_a = afd_pkg::MUL_W'(d_ff[afd_pkg::D_W-1:32]);
            mul_b = afd_pkg::MUL_W'(l2_ff);
         end
         afd_pkg::DP_TILT_MUL: begin
            mul_a = afd_pkg::MUL_W'(tilt_tangent);
            mul_b = afd_pkg::MUL_W'(abs_x);
         end
         default: mul_en = 1'b0;
      endcase
   end

   // One bit of the square root per step, from two bits of the radicand.
   assign cur_rem = {rem_ff, rad_ff[afd_pkg::RAD_W-1 -: 2]};
   assign trial   = (afd_pkg::REM_W+2)'({root_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      case (cmd.op)
         afd_pkg::DP_LOAD: begin
            ax_ff <= req_x;
            ay_ff <= req_y;
            az_ff <= req_z;
         end
         afd_pkg::DP_MUL_X: sq_ff <= '0;
         afd_pkg::DP_MUL_Y, afd_pkg::DP_MUL_Z, afd_pkg::DP_SQ_ADD: begin
            sq_ff <= sq_ff + prod_ff[afd_pkg::SQ_W-1:0];
         end
         afd_pkg::DP_SQRT_INIT: begin
            rad_ff  <= {sq_ff, 16'h0000};
            rem_ff  <= '0;
            root_ff <= '0;
         end
         afd_pkg::DP_SQRT_STEP: begin
            rad_ff <= {rad_ff[afd_pkg::RAD_W-3:0], 2'b00};
            if (cur_rem >= trial) begin
               rem_ff  <= afd_pkg::REM_W'(cur_rem - trial);
               root_ff <= {root_ff[afd_pkg::MAG_W-2:0], 1'b1};
            end else begin
               rem_ff  <= afd_pkg::REM_W'(cur_rem);
               root_ff <= {root_ff[afd_pkg::MAG_W-2:0], 1'b0};
            end
         end
         afd_pkg::DP_WRITE: win_mem[cmd.idx] <= root_ff;
         afd_pkg::DP_EV_CLEAR: begin
            s_ff  <= '0;
            q_ff  <= '0;
            l2_ff <= afd_pkg::L2_W'(cv_limit) * afd_pkg::L2_W'(cv_limit);
         end
         afd_pkg::DP_EV_READ: rd_ff <= win_mem[cmd.idx];
         afd_pkg::DP_EV_MUL: s_ff <= s_ff + afd_pkg::S_W'(rd_ff);
         afd_pkg::DP_EV_ACC: q_ff <= q_ff + afd_pkg::Q_W'(prod_ff[2*afd_pkg::MAG_W-1:0]);
         afd_pkg::DP_DIFF: begin
            s2_ff <= prod_ff[afd_pkg::D_W-1:0];
            d_ff  <= afd_pkg::D_W'(q_ff) * afd_pkg::D_W'(afd_pkg::WINDOW)
                     - prod_ff[afd_pkg::D_W-1:0];
         end
         afd_pkg::DP_PHI: lo_ff <= prod_ff[afd_pkg::LO_W-1:0];
         afd_pkg::DP_SUM: begin
            dl_ff <= {prod_ff[afd_pkg::DL_W-33:0], 32'h0000_0000}
                     + afd_pkg::DL_W'(lo_ff);
         end
         afd_pkg::DP_CMP: low_ff <= afd_pkg::DL_W'(s2_ff) < dl_ff;
         afd_pkg::DP_TILT_CMP: begin
            // A positive x axis means the horizontal component points the wrong way.
            fall_ff <= (!ax_ff[afd_pkg::AXIS_W-1] && (ax_ff != '0))
                    || (afd_pkg::TILT_W'({abs_y, 16'h0000}) > prod_ff[afd_pkg::TILT_W-1:0])
                    || (afd_pkg::TILT_W'({abs_z, 16'h0000}) > prod_ff[afd_pkg::TILT_W-1:0]);
         end
         default: ;
      endcase
   end

   assign stat.var_low = low_ff;
   assign stat.fall    = fall_ff;

endmodule

/* src/afd_ctrl.sv */
// Controller of the fall detector: phase tracking, tick counting, datapath
// sequencing and the result register. Depends on afd_pkg.
`timescale 1ns / 1ps

module afd_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_op,
   output logic                              req_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_fall,
   output logic                              rsp_low,
   input  logic [afd_pkg::SETTLE_W-1:0]      settle_ticks,
   output afd_pkg::dp_cmd_type               cmd,
   input  afd_pkg::dp_stat_type              stat
);

   typedef enum logic [1:0] {
      PH_COLLECT,
      PH_WAIT,
      PH_CHECK
   } phase_type;

   typedef enum logic [4:0] {
      S_IDLE, S_MX, S_MY, S_MZ, S_SQADD, S_SQINIT, S_SQRT, S_WRITE,
      S_EVCLR, S_RD, S_MUL, S_ACC, S_S2, S_DIFF, S_PLO, S_PHI, S_SUM,
      S_CMP, S_DEC, S_TMUL, S_TCMP, S_EMIT
   } state_type;

   localparam logic [afd_pkg::IDX_W-1:0]  LAST_IDX  = afd_pkg::IDX_W'(afd_pkg::WINDOW - 1);
   localparam logic [afd_pkg::STEP_W-1:0] LAST_STEP = afd_pkg::STEP_W'(afd_pkg::SQRT_STEPS - 1);

   state_type                       state_ff;
   phase_type                       phase_ff;
   logic [afd_pkg::IDX_W-1:0]       cnt_ff;
   logic [afd_pkg::IDX_W-1:0]       ev_ff;
   logic [afd_pkg::STEP_W-1:0]      step_ff;
   logic [afd_pkg::SETTLE_W-1:0]    wait_ff;
   logic [afd_pkg::SETTLE_W-1:0]    wait_cnt_in;
   logic                            emit_low_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_fall_ff;
   logic                            rsp_low_ff;

   assign wait_cnt_in = (wait_ff != '1) ? wait_ff + 1'b1 : wait_ff;
   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_fall    = rsp_fall_ff;
   assign rsp_low     = rsp_low_ff;

   always_comb begin
      cmd.idx = '0;
      case (state_ff)
         S_IDLE:   cmd.op = req_valid ? afd_pkg::DP_LOAD : afd_pkg::DP_NONE;
         S_MX:     cmd.op = afd_pkg::DP_MUL_X;
         S_MY:     cmd.op = afd_pkg::DP_MUL_Y;
         S_MZ:     cmd.op = afd_pkg::DP_MUL_Z;
         S_SQADD:  cmd.op = afd_pkg::DP_SQ_ADD;
         S_SQINIT: cmd.op = afd_pkg::DP_SQRT_INIT;
         S_SQRT:   cmd.op = afd_pkg::DP_SQRT_STEP;
         S_WRITE: begin
            cmd.op  = afd_pkg::DP_WRITE;
            cmd.idx = cnt_ff;
         end
         S_EVCLR:  cmd.op = afd_pkg::DP_EV_CLEAR;
         S_RD: begin
            cmd.op  = afd_pkg::DP_EV_READ;
            cmd.idx = ev_ff;
         end
         S_MUL:    cmd.op = afd_pkg::DP_EV_MUL;
         S_ACC:    cmd.op = afd_pkg::DP_EV_ACC;
         S_S2:     cmd.op = afd_pkg::DP_S2;
         S_DIFF:   cmd.op = afd_pkg::DP_DIFF;
         S_PLO:    cmd.op = afd_pkg::DP_PLO;
         S_PHI:    cmd.op = afd_pkg::DP_PHI;
         S_SUM:    cmd.op = afd_pkg::DP_SUM;
         S_CMP:    cmd.op = afd_pkg::DP_CMP;
         S_TMUL:   cmd.op = afd_pkg::DP_TILT_MUL;
         S_TCMP:   cmd.op = afd_pkg::DP_TILT_CMP;
         default:  cmd.op = afd_pkg::DP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_COLLECT;
         cnt_ff       <= '0;
         ev_ff        <= '0;
         step_ff      <= '0;
         wait_ff      <= '0;
         emit_low_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_fall_ff  <= 1'b0;
         rsp_low_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (req_op == afd_pkg::OPERATION_TICK) begin
                     if (phase_ff == PH_WAIT) begin
                        wait_ff <= wait_cnt_in;
                        if (wait_cnt_in >= settle_ticks) begin
                           phase_ff <= PH_CHECK;
                        end
                     end
                  end else if (phase_ff == PH_COLLECT) begin
                     state_ff <= S_MX;
                  end else if (phase_ff == PH_CHECK) begin
                     state_ff <= S_TMUL;
                  end
               end
            end
            S_MX:     state_ff <= S_MY;
            S_MY:     state_ff <= S_MZ;
            S_MZ:     state_ff <= S_SQADD;
            S_SQADD:  state_ff <= S_SQINIT;
            S_SQINIT: begin
               step_ff  <= '0;
               state_ff <= S_SQRT;
            end
            S_SQRT: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               if (cnt_ff == LAST_IDX) begin
                  cnt_ff   <= '0;
                  ev_ff    <= '0;
                  state_ff <= S_EVCLR;
               end else begin
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_EVCLR:  state_ff <= S_RD;
            S_RD:     state_ff <= S_MUL;
            S_MUL:    state_ff <= S_ACC;
            S_ACC: begin
               if (ev_ff == LAST_IDX) begin
                  state_ff <= S_S2;
               end else begin
                  ev_ff    <= ev_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_S2:     state_ff <= S_DIFF;
            S_DIFF:   state_ff <= S_PLO;
            S_PLO:    state_ff <= S_PHI;
            S_PHI:    state_ff <= S_SUM;
            S_SUM:    state_ff <= S_CMP;
            S_CMP:    state_ff <= S_DEC;
            S_DEC: begin
               if (stat.var_low) begin
                  wait_ff  <= '0;
                  phase_ff <= (settle_ticks == '0) ? PH_CHECK : PH_WAIT;
                  state_ff <= S_IDLE;
               end else begin
                  emit_low_ff <= 1'b0;
                  state_ff    <= S_EMIT;
               end
            end
            S_TMUL:   state_ff <= S_TCMP;
            S_TCMP: begin
               emit_low_ff <= 1'b1;
               phase_ff    <= PH_COLLECT;
               cnt_ff      <= '0;
               wait_ff     <= '0;
               state_ff    <= S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_fall_ff  <= emit_low_ff & stat.fall;
                  rsp_low_ff   <= emit_low_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* src/afd_checker.sv */
// Port-level checks of the fall detector, bound to the top level.
// Depends on assert_macros.svh and accel_fall_detector.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module afd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   logic       rsp_stall;
   logic       req_acc;
   logic [8:0] rsp_word;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_acc   = req_tvalid && req_tready;
   assign rsp_word  = {rsp_tuser, rsp_tdata};

   // After reset the block is ready for a request and has no response.
   `AFD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (req_tready && !rsp_tvalid))
   // A stalled response keeps its contents.
   `AFD_ASSERT_RST(a_rsp_hold, clock, reset, rsp_stall |=> (rsp_tvalid && $stable(rsp_word)))
   // A decision made without the tilt check is always no-fall.
   `AFD_ASSERT_RST(a_nolow_nofall, clock, reset, (rsp_tvalid && !rsp_tuser[0]) |-> !rsp_tdata[0])
   // A new response appears only after processing, with the input side free again.
   `AFD_ASSERT_RST(a_rsp_rise, clock, reset, $rose(rsp_tvalid) |-> (req_tready && !$past(req_acc)))

endmodule

bind accel_fall_detector afd_checker u_afd_checker (.*);

/* sim/accel_fall_detector_tb.sv */
// Self-checking testbench of the accelerometer fall detector top level.
// Depends on afd_pkg and accel_fall_detector; drives both streams and the register port.
`timescale 1ns / 1ps

// Predicted phase of the detector.
typedef enum int {COLLECTING, WAITING, CHECKING} fd_phase_type;

// The scoreboard keeps its own model of the detector. Every accepted request
// runs through that model, and any decision it produces is queued until the
// block presents its response.
class fall_scoreboard;
   bit [7:0]  cv_limit;
   bit [15:0] settle_ticks;
   bit [23:0] tilt_tangent;
   bit [23:0] mags[afd_pkg::WINDOW];
   int        mag_count;
   fd_phase_type phase;
   bit [15:0] ticks_waited;
   bit [1:0]  decisions[$];   // {low_variation, fall_detected}
   int        errors, responses, falls, tilt_checks;

   function new();
      cv_limit     = afd_pkg::CV_LIMIT_RST;
      settle_ticks = afd_pkg::SETTLE_TICKS_RST;
      tilt_tangent = afd_pkg::TILT_TANGENT_RST;
      mag_count    = 0;
      phase        = COLLECTING;
      ticks_waited = 0;
   endfunction

   function void set_reg(logic [1:0] idx, bit [31:0] value);
      case (idx)
         afd_pkg::REG_CV_LIMIT: cv_limit = value[7:0];
         afd_pkg::REG_SETTLE_TICKS: settle_ticks = value[15:0];
         afd_pkg::REG_TILT_TANGENT: tilt_tangent = value[23:0];
         default: ;
      endcase
   endfunction

   function int pending();
      return decisions.size();
   endfunction

   // Floor of the square root, one result bit per pair of input bits.
   function longint unsigned floor_root(longint unsigned n);
      longint unsigned root = 0;
      longint unsigned b = 64'h1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   // Mean over SD below the limit, checked without division in wide arithmetic.
   function bit still_window();
      logic [127:0] s = 0, q = 0, s2, d, lim;
      for (int i = 0; i < afd_pkg::WINDOW; i++) begin
         s += mags[i];
         q += 128'(mags[i]) * mags[i];
      end
      s2  = s * s;
      d   = afd_pkg::WINDOW * q - s2;
      lim = cv_limit * cv_limit;
      return s2 < d * lim;
   endfunction

   function bit tilted(int x, int y);
      longint unsigned ay;
      if (x < 0) return 1;
      if (x == 0) return y != 0;
      ay = (y < 0) ? -y : y;
      return (ay << 16) > longint'(tilt_tangent) * x;
   endfunction

   function void note_request(logic op, logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az);
      longint unsigned sq;
      int hx;
      bit fall;
      if (op == afd_pkg::OPERATION_TICK) begin
         if (phase == WAITING) begin
            if (ticks_waited != 16'hFFFF) ticks_waited++;
            if (ticks_waited >= settle_ticks) phase = CHECKING;
         end
         return;
      end
      if (phase == WAITING) return;
      if (phase == CHECKING) begin
         hx   = -int'(ax);
         fall = tilted(hx, ay) || tilted(hx, az);
         decisions.push_back({1'b1, fall});
         phase        = COLLECTING;
         mag_count    = 0;
         ticks_waited = 0;
         return;
      end
      sq = longint'(int'(ax) * int'(ax)) + longint'(int'(ay) * int'(ay))
         + longint'(int'(az) * int'(az));
      mags[mag_count] = floor_root(sq << 16);
      mag_count++;
      if (mag_count < afd_pkg::WINDOW) return;
      mag_count = 0;
      if (!still_window()) begin
         decisions.push_back(2'b00);
         return;
      end
      ticks_waited = 0;
      phase = (settle_ticks == 0) ? CHECKING : WAITING;
   endfunction

   task report_mismatch(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   task check_response(logic [7:0] data, logic [0:0] user);
      bit [1:0] want;
      if (decisions.size() == 0) begin
         report_mismatch($sformatf("response %h/%b with no decision pending", data, user));
         return;
      end
      want = decisions.pop_front();
      responses++;
      if (want[0]) falls++;
      if (want[1]) tilt_checks++;
      if (data !== {7'd0, want[0]})
         report_mismatch($sformatf("fall_detected field %h, expected %0d", data, want[0]));
      if (user !== want[1])
         report_mismatch($sformatf("low_variation %b, expected %0d", user, want[1]));
   endtask
endclass

module accel_fall_detector_tb;
   localparam int STALL_LIMIT = 20000;   // cycles without any handshake
   localparam int DRAIN_CYCLES = 120;    // longer than a full window sample

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [47:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [afd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   fall_scoreboard decision_board;
   bit send_gaps;        // sender idles in random bursts
   bit accept_gaps;      // receiver idles in random bursts
   int hold_off;         // receiver long hold, in cycles
   int stall_left;
   int requests_sent;
   int stall_cycles;

   accel_fall_detector dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // The receiver either serves a long hold requested by the stimulus or
   // drops ready for short random bursts. Only one assignment per edge.
   initial begin
      rsp_tready = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 0;
         end else if (accept_gaps && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // Both streams are sampled at the edge, before the block's own updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            decision_board.note_request(req_tuser[0], req_tdata[15:0], req_tdata[31:16],
                                        req_tdata[47:32]);
         if (rsp_tvalid && rsp_tready)
            decision_board.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // Watchdog: a run that stops making handshakes has hung.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Register write with a setup phase and an access phase; the scoreboard copy changes with it.
   task automatic write_reg(logic [1:0] idx, bit [31:0] value);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      decision_board.set_reg(idx, value);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      @(posedge clock);
   endtask

   // Valid stays high from one request to the next unless a gap is drawn.
   task automatic send_request(logic op, logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
      int gap;
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= {az, ay, ax};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
      send_request(afd_pkg::OPERATION_SAMPLE, ax, ay, az);
   endtask

   task automatic tick();
      send_request(afd_pkg::OPERATION_TICK, $urandom, $urandom, $urandom);
   endtask

   // Pause until every decision is out and the block has settled, so that
   // registers can be written safely.
   task automatic drain();
      req_tvalid <= 0;
      while (decision_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] axis_value();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return $urandom_range(0, 40) - 20;
         default: return $urandom;
      endcase
   endfunction

   // One well-formed pass: a window of samples, the settling ticks with a
   // little noise, then the sample that gets the tilt check.
   task automatic run_sequence();
      logic [15:0] bx, by, bz;
      int kind, n_ticks;
      kind = $urandom_range(0, 3);
      bx = $urandom;
      by = $urandom;
      bz = $urandom;
      for (int i = 0; i < afd_pkg::WINDOW; i++) begin
         case (kind)
            0: sample($urandom, $urandom, $urandom);
            1: sample(bx, by, bz);
            2: sample(bx + $urandom_range(0, 60), by + $urandom_range(0, 60), bz);
            default: sample(axis_value(), axis_value(), axis_value());
         endcase
      end
      if (decision_board.settle_ticks > 40) n_ticks = $urandom_range(0, 20);
      else n_ticks = decision_board.settle_ticks + $urandom_range(0, 2);
      for (int i = 0; i < n_ticks; i++) begin
         if ($urandom_range(0, 9) == 0) sample($urandom, $urandom, $urandom);
         tick();
      end
      sample(axis_value(), axis_value(), axis_value());
   endtask

   task automatic run_phase(bit [7:0] cv, bit [15:0] settle, bit [23:0] tangent, int n_items);
      drain();
      write_reg(afd_pkg::REG_CV_LIMIT, cv);
      write_reg(afd_pkg::REG_SETTLE_TICKS, settle);
      write_reg(afd_pkg::REG_TILT_TANGENT, tangent);
      n_items += requests_sent;
      while (requests_sent < n_items) begin
         if ($urandom_range(0, 7) == 0) begin
            // Noise: lone ticks and samples out of any sequence.
            if ($urandom_range(0, 1)) tick();
            else sample($urandom, $urandom, $urandom);
         end else begin
            run_sequence();
         end
      end
   endtask

   initial begin
      reset       = 1;
      req_tvalid  = 0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 0;
      csr_penable = 0;
      csr_pwrite  = 0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      hold_off    = 0;
      send_gaps   = 1;
      accept_gaps = 1;
      requests_sent = 0;
      decision_board = new();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: axis extremes, a zero vector, constant windows, ticks
      // in every phase, and the edge cases of the tilt test.
      write_reg(afd_pkg::REG_SETTLE_TICKS, 0);
      tick();
      sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
      sample(16'h8000, 16'h8000, 16'h8000);
      sample(16'h0000, 16'h0000, 16'h0000);
      sample(16'h0001, 16'hFFFF, 16'h0000);
      sample(16'h8000, 16'h0000, 16'h7FFF);
      tick();
      sample(16'h0000, 16'h0000, 16'h0000);   // level and flat: no fall
      for (int i = 0; i < afd_pkg::WINDOW; i++) sample(100, 200, 300);
      for (int i = 0; i < afd_pkg::WINDOW; i++) sample(i * 3000, 0, 7);
      sample(16'h0000, 16'h0005, 16'h0000);   // horizontal axis zero, tilted
      for (int i = 0; i < afd_pkg::WINDOW; i++) sample(0, i * 5000, 0);
      sample(16'h0064, 16'h0001, 16'h0000);   // pointing the wrong way
      drain();
      write_reg(afd_pkg::REG_SETTLE_TICKS, 2);
      for (int i = 0; i < afd_pkg::WINDOW; i++) sample(i * 4000, 9, 0);
      sample(16'h1234, 16'h0, 16'h0);         // dropped while settling
      tick();
      tick();
      sample(16'h8000, 16'h7FFF, 16'h8000);

      // Random phases across the register ranges.
      run_phase(10, 3, 244586, 130);
      run_phase(255, 0, 0, 120);

      // The receiver holds off while constant windows keep producing
      // decisions, so the block backs up and stalls its input.
      hold_off = 400;
      for (int i = 0; i < 6 * afd_pkg::WINDOW; i++) sample(500, 500, 500);
      drain();

      // Longest settling: the wait only ends once the limit is lowered.
      run_phase(1, 16'hFFFF, 24'hFFFFFF, 60);
      for (int i = 0; i < afd_pkg::WINDOW; i++) sample(i * 6000, 100, 0);
      tick();
      tick();
      tick();
      drain();
      write_reg(afd_pkg::REG_SETTLE_TICKS, 2);
      tick();
      sample($urandom, $urandom, $urandom);

      run_phase(0, 1, 65536, 100);
      run_phase(40, 5, 1000, 130);
      send_gaps   = 0;
      accept_gaps = 0;
      run_phase(20, 1, 113512, 120);

      drain();
      $display("Covered %0d requests and %0d decisions (%0d from tilt checks, %0d falls).",
               requests_sent, decision_board.responses, decision_board.tilt_checks,
               decision_board.falls);
      if (decision_board.errors == 0 && decision_board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
